FILE: src/spcc_pkg.sv
package spcc_pkg;

  localparam logic [31:0] FREE_MARK = 32'hFFFF_FFFF;
  localparam logic [31:0] WORD_MAX  = 32'hFFFF_FFFF;
  localparam int unsigned CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SPP  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PEND = 1'b1;

  // page size limits
  localparam logic [7:0] SPP_MIN = 8'd8;
  localparam logic [7:0] SPP_MAX = 8'd128;

  // request operations
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;
  localparam logic [1:0] OP_INVAL = 2'd3;

  // result actions
  localparam logic [1:0] ACT_READY = 2'd0;
  localparam logic [1:0] ACT_WB    = 2'd1;
  localparam logic [1:0] ACT_FILL  = 2'd2;
  localparam logic [1:0] ACT_FDONE = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_SCAN,
    S_HFIND,
    S_HOLD,
    S_HUPD,
    S_WB,
    S_FILL,
    S_READY,
    S_FLUSH,
    S_FDONE
  } spcc_state_t;

  // one page's state
  typedef struct packed {
    logic [31:0] base;
    logic [7:0]  count;
    logic [31:0] stamp;
    logic        dirty;
  } spcc_page_t;

  // command to the selected page cell
  typedef struct packed {
    logic        load;
    logic [31:0] base;
    logic [7:0]  count;
    logic        stamp_we;
    logic [31:0] stamp;
    logic        set_dirty;
    logic        clr_dirty;
    logic        free_all;
  } spcc_pcmd_t;

  // one eviction-history record
  typedef struct packed {
    logic [31:0] sector;
    logic [31:0] count;
    logic [31:0] stamp;
  } spcc_hist_t;

  // command to the selected history cell
  typedef struct packed {
    logic        upd;
    logic        newrec;
    logic [31:0] key;
    logic        stamp_we;
    logic [31:0] stamp;
  } spcc_hcmd_t;

  // result payload
  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  page;
    logic [31:0] run_start;
    logic [7:0]  run_count;
    logic [6:0]  sector_offset;
    logic        last;
  } spcc_res_t;

endpackage

FILE: src/spcc_in_if.sv
interface spcc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] sector;
  modport source (output valid, operation, sector, input ready);
  modport sink   (input valid, operation, sector, output ready);
endinterface

FILE: src/spcc_out_if.sv
interface spcc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [2:0]  page;
  logic [31:0] run_start;
  logic [7:0]  run_count;
  logic [6:0]  sector_offset;
  logic        last;
  modport source (output valid, action, page, run_start, run_count, sector_offset, last,
                  input ready);
  modport sink   (input valid, action, page, run_start, run_count, sector_offset, last,
                  output ready);
endinterface

FILE: src/spcc_page_cell.sv
module spcc_page_cell
  import spcc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       sel,
  input  spcc_pcmd_t cmd,
  output spcc_page_t st
);

  spcc_page_t st_r;

  // page state; reset and invalidate free the page
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.free_all) begin
      st_r.base  <= FREE_MARK;
      st_r.count <= 8'd0;
      st_r.stamp <= 32'd0;
      st_r.dirty <= 1'b0;
    end else if (sel) begin
      if (cmd.load) begin
        st_r.base  <= cmd.base;
        st_r.count <= cmd.count;
      end
      if (cmd.stamp_we) st_r.stamp <= cmd.stamp;
      if (cmd.set_dirty) begin
        st_r.dirty <= 1'b1;
      end else if (cmd.clr_dirty) begin
        st_r.dirty <= 1'b0;
      end
    end
  end

  assign st = st_r;

endmodule

FILE: src/spcc_hist_cell.sv
module spcc_hist_cell
  import spcc_pkg::*;
#(
  parameter int HW  = 3,
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          sel,
  input  spcc_hcmd_t    cmd,
  input  logic [31:0]   probe,
  input  logic          match_in,
  input  logic [HW-1:0] idx_in,
  output logic          match_out,
  output logic [HW-1:0] idx_out,
  output spcc_hist_t    st
);

  spcc_hist_t st_r;

  // record update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.sector <= FREE_MARK;
      st_r.count  <= 32'd0;
      st_r.stamp  <= 32'd0;
    end else if (sel) begin
      if (cmd.upd) begin
        if (cmd.newrec) begin
          st_r.sector <= cmd.key;
          st_r.count  <= 32'd1;
        end else begin
          st_r.count  <= st_r.count + 32'd1;
        end
      end
      if (cmd.upd || cmd.stamp_we) st_r.stamp <= cmd.stamp;
    end
  end

  // first-match chain: an earlier cell's match wins
  assign match_out = match_in || (st_r.sector == probe);
  assign idx_out   = match_in ? idx_in : HW'(IDX);
  assign st        = st_r;

endmodule

FILE: src/sector_page_cache_controller.sv
// Channel | Dir | Fields                                          | Handshake
// in_ch   | in  | operation, sector                               | valid/ready
// out_ch  | out | action, page, run_start, run_count,             | valid/ready
//         |     |   sector_offset, last                           |
// cfg     | in  | cfg_we, cfg_index, cfg_data                     | write on cfg_we
//
// One request at a time. An access computes a bit-serial remainder (page alignment),
// scans the pages in order, and on eviction does a history lookup, a search of the
// history records for the oldest when the victim has no record, then history update,
// writeback, fill and ready. Flush walks every page, then reports done.
// Synchronous active-low reset frees all pages and clears the history.
// A full output register stalls the sequencer on every result it emits.
module sector_page_cache_controller
  import spcc_pkg::*;
#(
  parameter int PAGES   = 8,
  parameter int HISTORY = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  spcc_in_if.sink              in_ch,
  spcc_out_if.source           out_ch
);

  localparam int PW = $clog2(PAGES);
  localparam int HW = (HISTORY > 1) ? $clog2(HISTORY) : 1;

  spcc_state_t state_r, state_nxt;

  logic [7:0]    spp_r;
  logic [31:0]   pe_r;
  logic [1:0]    op_r, op_nxt;
  logic [31:0]   sector_r, sector_nxt;
  logic [7:0]    sppe_r, sppe_nxt;
  logic [4:0]    bitcnt_r, bitcnt_nxt;
  logic [7:0]    rem_r, rem_nxt;
  logic [31:0]   base_r, base_nxt;
  logic [7:0]    fcount_r, fcount_nxt;
  logic [PW-1:0] idx_r, idx_nxt;
  logic [PW-1:0] victim_r, victim_nxt;
  logic [31:0]   old_acc_r, old_acc_nxt;
  logic [31:0]   old_ev_r, old_ev_nxt;
  logic [31:0]   old_evs_r, old_evs_nxt;
  logic [HW-1:0] h_r, h_nxt;
  logic          hnew_r, hnew_nxt;
  logic [HW-1:0] hidx_r, hidx_nxt;
  logic [31:0]   oldest_r, oldest_nxt;
  logic [31:0]   aclk_r, aclk_nxt;
  logic          out_valid_r;
  spcc_res_t     res_r, res_nxt;
  logic          emit;

  spcc_page_t    pst [PAGES];
  spcc_hist_t    hst [HISTORY];
  spcc_page_t    pr;
  spcc_hist_t    hr;
  spcc_pcmd_t    pcmd;
  spcc_hcmd_t    hcmd;
  logic [PW-1:0] pg_addr;
  logic [HW-1:0] h_addr;
  logic          mch [HISTORY+1];
  logic [HW-1:0] mix [HISTORY+1];
  logic          hm;
  logic [HW-1:0] midx;

  logic          in_fire, can_emit, hit, is_free, last_pg, last_h, div_done, lru_take;
  logic [31:0]   tick_val;
  logic [7:0]    rsh, rem_step, spp_clamp;
  logic [32:0]   nxt33, pe33, end33, fc33;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spp_r <= 8'd8;
      pe_r  <= WORD_MAX;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SPP:  spp_r <= cfg_data[7:0];
        CFG_PEND: pe_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // page cells
  assign pg_addr = (state_r == S_SCAN || state_r == S_FLUSH) ? idx_r : victim_r;

  for (genvar i = 0; i < PAGES; i++) begin : g_page
    spcc_page_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .sel   (pg_addr == PW'(i)),
      .cmd   (pcmd),
      .st    (pst[i])
    );
  end

  assign pr = pst[pg_addr];

  // history cells, chained for first match on the probed page base
  assign mch[0] = 1'b0;
  assign mix[0] = '0;

  for (genvar j = 0; j < HISTORY; j++) begin : g_hist
    spcc_hist_cell #(.HW(HW), .IDX(j)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .sel       (h_addr == HW'(j)),
      .cmd       (hcmd),
      .probe     (pr.base),
      .match_in  (mch[j]),
      .idx_in    (mix[j]),
      .match_out (mch[j+1]),
      .idx_out   (mix[j+1]),
      .st        (hst[j])
    );
  end

  assign hm     = mch[HISTORY];
  assign midx   = mix[HISTORY];
  assign h_addr = (state_r == S_HOLD) ? hidx_r : ((state_r == S_HUPD) ? h_r : midx);
  assign hr     = hst[h_addr];

  // shared conditions
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign can_emit = !out_valid_r || out_ch.ready;
  assign hit      = (sector_r >= pr.base) &&
                    ({1'b0, sector_r} < ({1'b0, pr.base} + {25'b0, pr.count}));
  assign is_free  = (pr.base == FREE_MARK);
  assign last_pg  = (idx_r == PW'(PAGES - 1));
  assign last_h   = (hidx_r == HW'(HISTORY - 1));
  assign div_done = (bitcnt_r == 5'd0);
  assign tick_val = aclk_r + 32'd1;
  assign lru_take = (pr.stamp < old_acc_r) &&
                    !(hm && (hr.count >= old_ev_r) && (hr.stamp >= old_evs_r));

  // remainder step, one sector bit per cycle
  assign rsh      = {rem_r[6:0], sector_r[bitcnt_r]};
  assign rem_step = (rsh >= sppe_r) ? (rsh - sppe_r) : rsh;
  assign spp_clamp = (spp_r < SPP_MIN) ? SPP_MIN : ((spp_r > SPP_MAX) ? SPP_MAX : spp_r);

  // fill run, clipped at the partition end
  assign nxt33 = {1'b0, base_r} + {25'b0, sppe_r};
  assign pe33  = {1'b0, pe_r};
  assign end33 = (nxt33 > pe33) ? pe33 : nxt33;
  assign fc33  = (end33 > {1'b0, base_r}) ? (end33 - {1'b0, base_r}) : 33'd0;

  function automatic logic [2:0] pg3(input logic [PW-1:0] p);
    logic [PW+2:0] w;
    w = {3'b000, p};
    return w[2:0];
  endfunction

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_ch.operation == OP_READ || in_ch.operation == OP_WRITE) ?
                      S_DIV : S_FLUSH;
        end
      end
      S_DIV:   if (div_done) state_nxt = S_SCAN;
      S_SCAN: begin
        if (hit) begin
          if (can_emit) state_nxt = S_IDLE;
        end else if (is_free) begin
          state_nxt = S_FILL;
        end else if (last_pg) begin
          state_nxt = S_HFIND;
        end
      end
      S_HFIND: state_nxt = hm ? S_HUPD : S_HOLD;
      S_HOLD:  if (last_h) state_nxt = S_HUPD;
      S_HUPD:  state_nxt = S_WB;
      S_WB:    if (!pr.dirty || can_emit) state_nxt = S_FILL;
      S_FILL:  if (can_emit) state_nxt = S_READY;
      S_READY: if (can_emit) state_nxt = S_IDLE;
      S_FLUSH: if ((!pr.dirty || can_emit) && last_pg) state_nxt = S_FDONE;
      S_FDONE: if (can_emit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and cell commands
  always_comb begin
    op_nxt      = op_r;
    sector_nxt  = sector_r;
    sppe_nxt    = sppe_r;
    bitcnt_nxt  = bitcnt_r;
    rem_nxt     = rem_r;
    base_nxt    = base_r;
    fcount_nxt  = fcount_r;
    idx_nxt     = idx_r;
    victim_nxt  = victim_r;
    old_acc_nxt = old_acc_r;
    old_ev_nxt  = old_ev_r;
    old_evs_nxt = old_evs_r;
    h_nxt       = h_r;
    hnew_nxt    = hnew_r;
    hidx_nxt    = hidx_r;
    oldest_nxt  = oldest_r;
    aclk_nxt    = aclk_r;
    pcmd        = '0;
    hcmd        = '0;
    hcmd.key    = pr.base;
    hcmd.stamp  = tick_val;
    pcmd.stamp  = tick_val;
    emit        = 1'b0;
    res_nxt     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt      = in_ch.operation;
          sector_nxt  = in_ch.sector;
          sppe_nxt    = spp_clamp;
          bitcnt_nxt  = 5'd31;
          rem_nxt     = 8'd0;
          idx_nxt     = '0;
          victim_nxt  = '0;
          old_acc_nxt = WORD_MAX;
          old_ev_nxt  = WORD_MAX;
          old_evs_nxt = 32'd0;
        end
      end
      S_DIV: begin
        rem_nxt    = rem_step;
        bitcnt_nxt = bitcnt_r - 5'd1;
        if (div_done) base_nxt = sector_r - {24'b0, rem_step};
      end
      S_SCAN: begin
        if (hit) begin
          if (can_emit) begin
            aclk_nxt           = tick_val;
            pcmd.stamp_we      = 1'b1;
            pcmd.set_dirty     = (op_r == OP_WRITE);
            hcmd.stamp_we      = hm;
            emit               = 1'b1;
            res_nxt.action     = ACT_READY;
            res_nxt.page       = pg3(idx_r);
            res_nxt.run_start  = pr.base;
            res_nxt.run_count  = pr.count;
            res_nxt.sector_offset = 7'(sector_r - pr.base);
            res_nxt.last       = 1'b1;
          end
        end else if (is_free) begin
          victim_nxt = idx_r;
        end else begin
          if (lru_take) begin
            victim_nxt = idx_r;
            if (hm) begin
              old_acc_nxt = WORD_MAX;
              old_ev_nxt  = hr.count;
              old_evs_nxt = hr.stamp;
            end else begin
              old_acc_nxt = pr.stamp;
              old_ev_nxt  = 32'd0;
              old_evs_nxt = 32'd0;
            end
          end
          idx_nxt = idx_r + PW'(1);
        end
      end
      S_HFIND: begin
        hidx_nxt   = '0;
        oldest_nxt = WORD_MAX;
        if (hm) begin
          h_nxt    = midx;
          hnew_nxt = 1'b0;
        end else begin
          h_nxt    = '0;
          hnew_nxt = 1'b1;
        end
      end
      S_HOLD: begin
        if (hr.stamp < oldest_r) begin
          oldest_nxt = hr.stamp;
          h_nxt      = hidx_r;
        end
        hidx_nxt = hidx_r + HW'(1);
      end
      S_HUPD: begin
        hcmd.upd    = 1'b1;
        hcmd.newrec = hnew_r;
        aclk_nxt    = tick_val;
      end
      S_WB: begin
        if (pr.dirty && can_emit) begin
          pcmd.clr_dirty    = 1'b1;
          emit              = 1'b1;
          res_nxt.action    = ACT_WB;
          res_nxt.page      = pg3(victim_r);
          res_nxt.run_start = pr.base;
          res_nxt.run_count = pr.count;
        end
      end
      S_FILL: begin
        if (can_emit) begin
          pcmd.load         = 1'b1;
          pcmd.base         = base_r;
          pcmd.count        = fc33[7:0];
          fcount_nxt        = fc33[7:0];
          emit              = 1'b1;
          res_nxt.action    = ACT_FILL;
          res_nxt.page      = pg3(victim_r);
          res_nxt.run_start = base_r;
          res_nxt.run_count = fc33[7:0];
        end
      end
      S_READY: begin
        if (can_emit) begin
          aclk_nxt              = tick_val;
          pcmd.stamp_we         = 1'b1;
          pcmd.set_dirty        = (op_r == OP_WRITE);
          emit                  = 1'b1;
          res_nxt.action        = ACT_READY;
          res_nxt.page          = pg3(victim_r);
          res_nxt.run_start     = base_r;
          res_nxt.run_count     = fcount_r;
          res_nxt.sector_offset = rem_r[6:0];
          res_nxt.last          = 1'b1;
        end
      end
      S_FLUSH: begin
        if (!pr.dirty || can_emit) begin
          idx_nxt = idx_r + PW'(1);
          if (pr.dirty) begin
            pcmd.clr_dirty    = 1'b1;
            emit              = 1'b1;
            res_nxt.action    = ACT_WB;
            res_nxt.page      = pg3(idx_r);
            res_nxt.run_start = pr.base;
            res_nxt.run_count = pr.count;
          end
        end
      end
      S_FDONE: begin
        if (can_emit) begin
          pcmd.free_all  = (op_r == OP_INVAL);
          emit           = 1'b1;
          res_nxt.action = ACT_FDONE;
          res_nxt.last   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      aclk_r      <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      aclk_r  <= aclk_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    sector_r  <= sector_nxt;
    sppe_r    <= sppe_nxt;
    bitcnt_r  <= bitcnt_nxt;
    rem_r     <= rem_nxt;
    base_r    <= base_nxt;
    fcount_r  <= fcount_nxt;
    idx_r     <= idx_nxt;
    victim_r  <= victim_nxt;
    old_acc_r <= old_acc_nxt;
    old_ev_r  <= old_ev_nxt;
    old_evs_r <= old_evs_nxt;
    h_r       <= h_nxt;
    hnew_r    <= hnew_nxt;
    hidx_r    <= hidx_nxt;
    oldest_r  <= oldest_nxt;
    if (emit) res_r <= res_nxt;
  end

  // ports
  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.action        = res_r.action;
  assign out_ch.page          = res_r.page;
  assign out_ch.run_start     = res_r.run_start;
  assign out_ch.run_count     = res_r.run_count;
  assign out_ch.sector_offset = res_r.sector_offset;
  assign out_ch.last          = res_r.last;

endmodule

FILE: dv/spcc_checker.sv
module spcc_checker
  import spcc_pkg::*;
#(
  parameter int PAGES   = 8,
  parameter int HISTORY = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  spcc_in_if                   in_ch,
  spcc_out_if                  out_ch,
  output int                   fail_count,
  output int                   pending,
  output int                   req_count,
  output int                   res_count,
  output int                   miss_count,
  output int                   wb_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow of the cache tags, history and registers
  logic [7:0]  spp_reg;
  logic [31:0] pend_reg;
  logic [31:0] pg_base [PAGES];
  logic [7:0]  pg_cnt [PAGES];
  logic [31:0] pg_stamp [PAGES];
  logic        pg_dirty [PAGES];
  logic [31:0] hs_sector [HISTORY];
  logic [31:0] hs_cnt [HISTORY];
  logic [31:0] hs_stamp [HISTORY];
  logic [31:0] access_clk;

  spcc_res_t expected_results[$];

  assign pending = expected_results.size();

  function automatic logic [31:0] next_stamp();
    access_clk = access_clk + 32'd1;
    return access_clk;
  endfunction

  function automatic int history_slot(logic [31:0] key);
    for (int i = 0; i < HISTORY; i++)
      if (hs_sector[i] == key) return i;
    return -1;
  endfunction

  function automatic void push_result(logic [1:0] act, int pg, logic [31:0] start,
                                      logic [7:0] cnt, logic [31:0] off, logic lst);
    spcc_res_t r;
    r.action        = act;
    r.page          = pg[2:0];
    r.run_start     = start;
    r.run_count     = cnt;
    r.sector_offset = off[6:0];
    r.last          = lst;
    expected_results.push_back(r);
    if (act == ACT_WB) wb_count++;
  endfunction

  function automatic void clear_state();
    spp_reg    = 8'd8;
    pend_reg   = '1;
    access_clk = '0;
    for (int i = 0; i < PAGES; i++) begin
      pg_base[i] = FREE_MARK; pg_cnt[i] = '0; pg_stamp[i] = '0; pg_dirty[i] = 1'b0;
    end
    for (int i = 0; i < HISTORY; i++) begin
      hs_sector[i] = '1; hs_cnt[i] = '0; hs_stamp[i] = '0;
    end
  endfunction

  // tag lookup, victim choice, writeback and fill of one access
  function automatic void predict_access(logic [31:0] sec, logic is_write);
    int victim;
    int h;
    logic found_free;
    logic [31:0] old_access, old_ev, old_evs, oldest, spp;
    logic [63:0] base, nxt;
    victim = 0;
    found_free = 1'b0;
    old_access = WORD_MAX;
    old_ev = WORD_MAX;
    old_evs = '0;
    spp = {24'd0, spp_reg};
    if (spp < 32'd8) spp = 32'd8;
    if (spp > 32'd128) spp = 32'd128;

    for (int i = 0; i < PAGES; i++) begin
      h = history_slot(pg_base[i]);
      if (sec >= pg_base[i] && {32'd0, sec} < {32'd0, pg_base[i]} + pg_cnt[i]) begin
        pg_stamp[i] = next_stamp();
        if (h >= 0) hs_stamp[h] = pg_stamp[i];
        if (is_write) pg_dirty[i] = 1'b1;
        push_result(ACT_READY, i, pg_base[i], pg_cnt[i], sec - pg_base[i], 1'b1);
        return;
      end
      if (pg_base[i] == FREE_MARK) begin
        victim = i;
        found_free = 1'b1;
        break;
      end
      if (pg_stamp[i] < old_access) begin
        if (h >= 0) begin
          if (hs_cnt[h] >= old_ev && hs_stamp[h] >= old_evs) continue;
          old_access = WORD_MAX;
          old_ev = hs_cnt[h];
          old_evs = hs_stamp[h];
        end else begin
          old_access = pg_stamp[i];
          old_ev = '0;
          old_evs = '0;
        end
        victim = i;
      end
    end

    miss_count++;
    if (!found_free) begin
      h = history_slot(pg_base[victim]);
      if (h < 0) begin
        oldest = WORD_MAX;
        h = 0;
        for (int i = 0; i < HISTORY; i++)
          if (hs_stamp[i] < oldest) begin
            oldest = hs_stamp[i];
            h = i;
          end
        hs_sector[h] = pg_base[victim];
        hs_cnt[h] = '0;
      end
      hs_cnt[h] = hs_cnt[h] + 32'd1;
      hs_stamp[h] = next_stamp();
      if (pg_dirty[victim]) begin
        push_result(ACT_WB, victim, pg_base[victim], pg_cnt[victim], '0, 1'b0);
        pg_dirty[victim] = 1'b0;
      end
    end

    base = ({32'd0, sec} / spp) * spp;
    nxt = base + spp;
    if (nxt > {32'd0, pend_reg}) nxt = {32'd0, pend_reg};
    pg_base[victim] = base[31:0];
    pg_cnt[victim] = (nxt > base) ? 8'(nxt - base) : 8'd0;
    push_result(ACT_FILL, victim, pg_base[victim], pg_cnt[victim], '0, 1'b0);
    pg_stamp[victim] = next_stamp();
    if (is_write) pg_dirty[victim] = 1'b1;
    push_result(ACT_READY, victim, pg_base[victim], pg_cnt[victim],
                sec - pg_base[victim], 1'b1);
  endfunction

  function automatic void predict_request(logic [1:0] op, logic [31:0] sec);
    if (op == OP_READ || op == OP_WRITE) begin
      predict_access(sec, op == OP_WRITE);
      return;
    end
    // flush writes back dirty pages; invalidate also frees every page
    for (int i = 0; i < PAGES; i++) begin
      if (pg_dirty[i]) push_result(ACT_WB, i, pg_base[i], pg_cnt[i], '0, 1'b0);
      pg_dirty[i] = 1'b0;
    end
    if (op == OP_INVAL)
      for (int i = 0; i < PAGES; i++) begin
        pg_base[i] = FREE_MARK; pg_stamp[i] = '0; pg_cnt[i] = '0;
      end
    push_result(ACT_FDONE, 0, '0, '0, '0, 1'b1);
  endfunction

  initial begin
    fail_count = 0; req_count = 0; res_count = 0; miss_count = 0; wb_count = 0;
    clear_state();
  end

  // watch the channels at each edge
  always @(posedge clk) begin
    spcc_res_t got, want;
    if (!rst_n) begin
      clear_state();
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_SPP) spp_reg = cfg_data[7:0];
        else if (cfg_index == CFG_PEND) pend_reg = cfg_data;
      end
      if (in_ch.valid && in_ch.ready) begin
        req_count++;
        predict_request(in_ch.operation, in_ch.sector);
      end
      if (out_ch.valid && out_ch.ready) begin
        res_count++;
        got.action        = out_ch.action;
        got.page          = out_ch.page;
        got.run_start     = out_ch.run_start;
        got.run_count     = out_ch.run_count;
        got.sector_offset = out_ch.sector_offset;
        got.last          = out_ch.last;
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("ERROR: unexpected result act=%0d page=%0d start=%h cnt=%0d",
                     got.action, got.page, got.run_start, got.run_count);
        end else begin
          want = expected_results.pop_front();
          if (got.action !== want.action || got.page !== want.page ||
              got.run_start !== want.run_start || got.run_count !== want.run_count ||
              got.sector_offset !== want.sector_offset || got.last !== want.last) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"ERROR: result %0d exp act=%0d page=%0d start=%h cnt=%0d ",
                        "off=%0d last=%0d got act=%0d page=%0d start=%h cnt=%0d ",
                        "off=%0d last=%0d"}, res_count,
                       want.action, want.page, want.run_start, want.run_count,
                       want.sector_offset, want.last,
                       got.action, got.page, got.run_start, got.run_count,
                       got.sector_offset, got.last);
          end
        end
      end
    end
  end

endmodule

FILE: dv/sector_page_cache_controller_tb.sv
module sector_page_cache_controller_tb;
  import spcc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int SETTLE_CYCLES  = 120;
  localparam int LONG_HOLD      = 400;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;

  int  fail_count, pending, req_count, res_count, miss_count, wb_count;
  bit  idle_on;
  bit  hold_req;
  int  hold_left;
  int  ready_gap;
  int  quiet_cycles;
  int  cfg_phases;
  logic [31:0] page_pool[12];

  spcc_in_if  in_ch();
  spcc_out_if out_ch();

  sector_page_cache_controller dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
  );

  spcc_checker chk (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch),
    .fail_count(fail_count), .pending(pending), .req_count(req_count),
    .res_count(res_count), .miss_count(miss_count), .wb_count(wb_count)
  );

  always #5 clk = ~clk;

  // result side: random stalls, plus one long hold when asked
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left = 0;
      ready_gap = 0;
    end else begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (ready_gap > 0) begin
        ready_gap--;
        out_ch.ready <= (ready_gap == 0);
      end else if (out_ch.valid && out_ch.ready) begin
        ready_gap = idle_on ? $urandom_range(0, 16) : 0;
        out_ch.ready <= (ready_gap == 0);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // no progress on either channel for too long ends the run
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_request(logic [1:0] op, logic [31:0] sec);
    int gap;
    gap = idle_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.sector    <= sec;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // registers change only once the block has drained
  task automatic write_config(logic [7:0] spp, logic [31:0] pend);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SPP;
    cfg_data  <= {24'd0, spp};
    @(posedge clk);
    cfg_index <= CFG_PEND;
    cfg_data  <= pend;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_phases++;
  endtask

  // mostly accesses to a small set of pages, some noise
  task automatic random_requests(int n);
    logic [1:0]  op;
    logic [31:0] sec;
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 44) op = OP_READ;
      else if (r < 88) op = OP_WRITE;
      else if (r < 95) op = OP_FLUSH;
      else op = OP_INVAL;
      if ($urandom_range(0, 9) == 0) sec = $urandom_range(32'hFFFF_FFFE, 0);
      else sec = page_pool[$urandom_range(0, 11)] + $urandom_range(0, 140);
      send_request(op, sec);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_SPP;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_READ;
    in_ch.sector = '0;
    out_ch.ready = 1'b0;
    idle_on = 1'b0;
    hold_req = 1'b0;
    quiet_cycles = 0;
    cfg_phases = 0;
    for (int i = 0; i < 12; i++) page_pool[i] = i * 37 * 8;
    page_pool[11] = 32'hFFFF_FF00;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: hits, misses, edge sectors, dirty eviction, flush, invalidate
    send_request(OP_READ, 32'd0);
    send_request(OP_WRITE, 32'd7);
    send_request(OP_READ, 32'hFFFF_FFFE);
    send_request(OP_WRITE, 32'hFFFF_FFF9);
    for (int i = 1; i <= 7; i++) send_request(OP_WRITE, i * 16 + 3);
    send_request(OP_READ, 32'd1000);
    send_request(OP_READ, 32'd0);
    send_request(OP_FLUSH, 32'd0);
    send_request(OP_WRITE, 32'd17);
    send_request(OP_INVAL, 32'hFFFF_FFFE);
    send_request(OP_READ, 32'd16);
    send_request(OP_FLUSH, 32'd5);

    // fills past the partition end: clipped and empty pages
    write_config(8'd128, 32'd200);
    send_request(OP_WRITE, 32'd130);
    send_request(OP_READ, 32'd300);
    send_request(OP_READ, 32'd300);
    send_request(OP_INVAL, 32'd0);

    // random phases across page sizes and partition ends
    idle_on = 1'b1;
    write_config(8'd8, 32'hFFFF_FFFF);
    random_requests(50);
    write_config(8'd128, 32'hFFFF_FFFF);
    hold_req = 1'b1;
    random_requests(50);
    write_config(8'd0, 32'd1500);
    idle_on = 1'b0;
    random_requests(55);
    write_config(8'd255, 32'd0);
    idle_on = 1'b1;
    random_requests(40);
    write_config(8'd13, 32'hFFFF_FF20);
    random_requests(50);
    write_config(8'd64, 32'd2000);
    random_requests(64);

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d requests, %0d results, %0d misses, %0d writebacks",
             req_count, res_count, miss_count, wb_count);
    $display("over %0d register settings, with stalls and a long result hold",
             cfg_phases);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule
